>>> src/fsmi_pkg.sv
package fsmi_pkg;

    localparam int NEEDLE_MAX_DEF = 16;
    localparam int INDEX_BITS_DEF = 16;

    localparam int LEN_FIELD_W = 5;
    localparam int IDX_FIELD_W = 16;

    // lowercase range and the distance to uppercase
    localparam logic [7:0] LOWER_FIRST = 8'd97;
    localparam logic [7:0] LOWER_END   = 8'd123;
    localparam logic [7:0] CASE_GAP    = 8'd32;

    typedef enum logic [1:0] {
        MODE_PATTERN = 2'd0,
        MODE_TEXT    = 2'd1,
        MODE_END     = 2'd2
    } mode_t;

    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic REG_FOLD_CASE      = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] slot;
        logic [7:0] byte_value;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic [LEN_FIELD_W-1:0] pattern_length;
        logic                   fold_case;
    } cfg_t;

    typedef struct packed {
        logic                   found;
        logic [IDX_FIELD_W-1:0] match_index;
        logic                   overflow;
    } res_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= LOWER_FIRST && b < LOWER_END)
        begin
            r = b - CASE_GAP;
        end
        return r;
    endfunction

    // true for the words that close a text and produce a result
    function automatic logic ends_text(input item_t it);
        return (mode_t'(it.mode) == MODE_TEXT && it.final_byte)
            || (mode_t'(it.mode) == MODE_END);
    endfunction

endpackage

>>> src/first_substring_match_index.sv
// Output path: the result of a closing word (last text byte or end marker) goes from
//   the input register to the result register, which drives m_tvalid.
// Throughput: one word per cycle while no closing word is held by a full result register;
//   the window shift and parallel byte compare finish between the two registers.
// Reset: rst_n clears the text window, counters and match state; pattern_length
//   resets to 0 and fold_case to 1. Pattern bytes are undefined until loaded.
module first_substring_match_index #(
    parameter int NEEDLE_MAX = fsmi_pkg::NEEDLE_MAX_DEF,
    parameter int INDEX_BITS = fsmi_pkg::INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] slot, [11:4] byte_value, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] match_index
    output logic [1:0]  m_tuser,   // [0] found, [1] overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fsmi_pkg::*;

    cfg_t  cfg;
    res_t  res;
    item_t in_item;
    item_t item_reg;
    logic  item_valid_reg;
    res_t  out_reg;
    logic  out_valid_reg;
    logic  advance;
    logic  produces;

    fsmi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_item.mode       = s_tuser;
    assign in_item.slot       = s_tdata[3:0];
    assign in_item.byte_value = s_tdata[11:4];
    assign in_item.final_byte = s_tlast;

    assign produces = ends_text(item_reg);
    assign advance  = item_valid_reg && (!produces || !out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            item_reg <= in_item;
        end
    end

    fsmi_engine #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .INDEX_BITS (INDEX_BITS)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produces)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produces)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.match_index;
    assign m_tuser  = {out_reg.overflow, out_reg.found};

endmodule

>>> src/fsmi_cfg.sv
module fsmi_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output fsmi_pkg::cfg_t     cfg
);
    import fsmi_pkg::*;

    logic [LEN_FIELD_W-1:0] pattern_length_reg;
    logic                   fold_case_reg;
    logic                   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            fold_case_reg      <= 1'b1;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[LEN_FIELD_W-1:0];
                REG_FOLD_CASE:      fold_case_reg      <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PATTERN_LENGTH: prdata = {{(32-LEN_FIELD_W){1'b0}}, pattern_length_reg};
            REG_FOLD_CASE:      prdata = {31'b0, fold_case_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.fold_case      = fold_case_reg;

endmodule

>>> src/fsmi_engine.sv
module fsmi_engine #(
    parameter int NEEDLE_MAX = fsmi_pkg::NEEDLE_MAX_DEF,
    parameter int INDEX_BITS = fsmi_pkg::INDEX_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  fsmi_pkg::item_t item,
    input  fsmi_pkg::cfg_t  cfg,
    output fsmi_pkg::res_t  res
);
    import fsmi_pkg::*;

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int SUM_W = INDEX_BITS + LEN_W;
    localparam logic [INDEX_BITS-1:0] IDX_ALL_ONES = {INDEX_BITS{1'b1}};

    logic [7:0]            pattern_reg [NEEDLE_MAX];
    logic [7:0]            window_reg  [NEEDLE_MAX];
    logic [7:0]            window_next [NEEDLE_MAX];
    logic [LEN_W-1:0]      fill_reg, fill_next, fill_inc;
    logic [INDEX_BITS-1:0] count_reg, count_next, count_inc;
    logic                  sat_reg, sat_next, sat_inc;
    logic                  seen_reg, seen_next;
    logic [INDEX_BITS-1:0] start_reg, start_next, start_hit;

    logic [LEN_W+LEN_FIELD_W-1:0] pl_ext;
    logic [LEN_W-1:0]      len;
    logic [7:0]            shifted [NEEDLE_MAX];
    logic [7:0]            aligned [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] eq;
    logic [SUM_W-1:0]      diff;
    logic [IDX_FIELD_W+INDEX_BITS-1:0] start_ext;
    logic                  take, hit, emit, pat_wr;

    always_comb
    begin
        pl_ext = {{LEN_W{1'b0}}, cfg.pattern_length};
        if (pl_ext > (LEN_W+LEN_FIELD_W)'(NEEDLE_MAX))
        begin
            len = LEN_W'(NEEDLE_MAX);
        end
        else
        begin
            len = pl_ext[LEN_W-1:0];
        end
    end

    assign take   = go && mode_t'(item.mode) == MODE_TEXT && !seen_reg && len != '0;
    assign emit   = go && ends_text(item);
    assign pat_wr = go && mode_t'(item.mode) == MODE_PATTERN;

    // window after the new byte; entry 0 is the newest
    always_comb
    begin
        shifted[0] = item.byte_value;
        for (int j = 1; j < NEEDLE_MAX; j++)
        begin
            shifted[j] = window_reg[j-1];
        end
    end

    // pattern byte k lines up with window entry len-1-k
    always_comb
    begin
        for (int k = 0; k < NEEDLE_MAX; k++)
        begin
            aligned[k] = '0;
            for (int j = 0; j < NEEDLE_MAX; j++)
            begin
                if (j + k + 1 == int'(len))
                begin
                    aligned[k] = shifted[j];
                end
            end
            eq[k] = (k >= int'(len))
                 || (fold_byte(pattern_reg[k], cfg.fold_case)
                     == fold_byte(aligned[k], cfg.fold_case));
        end
    end

    assign fill_inc  = (int'(fill_reg) < NEEDLE_MAX) ? fill_reg + LEN_W'(1) : fill_reg;
    assign sat_inc   = sat_reg || (count_reg == IDX_ALL_ONES);
    assign count_inc = (count_reg == IDX_ALL_ONES) ? count_reg : count_reg + INDEX_BITS'(1);
    assign hit       = take && (fill_inc >= len) && (&eq);

    assign diff      = {{LEN_W{1'b0}}, count_reg} + SUM_W'(1) - {{INDEX_BITS{1'b0}}, len};
    assign start_hit = sat_inc ? IDX_ALL_ONES : diff[INDEX_BITS-1:0];

    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        sat_next    = sat_reg;
        seen_next   = seen_reg;
        start_next  = start_reg;
        if (take)
        begin
            window_next = shifted;
            fill_next   = fill_inc;
            count_next  = count_inc;
            sat_next    = sat_inc;
        end
        if (hit)
        begin
            seen_next  = 1'b1;
            start_next = start_hit;
        end

        start_ext = {{IDX_FIELD_W{1'b0}}, start_next};
        if (len == '0)
        begin
            res.found       = 1'b1;
            res.match_index = '0;
            res.overflow    = 1'b0;
        end
        else if (seen_next)
        begin
            res.found       = 1'b1;
            res.match_index = start_ext[IDX_FIELD_W-1:0];
            res.overflow    = sat_next;
        end
        else
        begin
            res.found       = 1'b0;
            res.match_index = '0;
            res.overflow    = sat_next;
        end

        if (emit)
        begin
            for (int j = 0; j < NEEDLE_MAX; j++)
            begin
                window_next[j] = '0;
            end
            fill_next  = '0;
            count_next = '0;
            sat_next   = 1'b0;
            seen_next  = 1'b0;
            start_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NEEDLE_MAX; j++)
            begin
                window_reg[j] <= '0;
            end
            fill_reg  <= '0;
            count_reg <= '0;
            sat_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            sat_reg    <= sat_next;
            seen_reg   <= seen_next;
            start_reg  <= start_next;
        end
    end

    // pattern store: no reset, slots at or above NEEDLE_MAX are dropped
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NEEDLE_MAX; j++)
        begin
            if (pat_wr && int'(item.slot) == j)
            begin
                pattern_reg[j] <= item.byte_value;
            end
        end
    end

endmodule

>>> sim/fsmi_checker.sv
`timescale 1ns / 1ps

module fsmi_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] slot, [11:4] byte_value, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic        s_tlast,   // final_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] match_index
    input  logic [1:0]  m_tuser,   // [0] found, [1] overflow
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          errors,
    output int          waiting
);
    import fsmi_pkg::*;

    localparam int          NEEDLE  = NEEDLE_MAX_DEF;
    localparam int unsigned IDX_TOP = (1 << INDEX_BITS_DEF) - 1;

    localparam logic [2:0] ADDR_PATTERN_LENGTH = {REG_PATTERN_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_FOLD_CASE      = {REG_FOLD_CASE, 2'b00};

    logic [7:0]  pat_mem [NEEDLE];
    logic [7:0]  win [NEEDLE];        // win[0] holds the newest text byte
    int unsigned win_fill;
    int unsigned text_pos;
    int unsigned first_pos;
    bit          pos_saturated;
    bit          hit_seen;
    logic [4:0]  len_reg;
    logic        fold_reg;
    res_t        result_fifo [$];
    int          err_cnt;

    function automatic int unsigned used_len();
        return (len_reg > NEEDLE) ? NEEDLE : len_reg;
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] b);
        return (fold_reg && b >= LOWER_FIRST && b < LOWER_END) ? b - CASE_GAP : b;
    endfunction

    function automatic void shift_in(input logic [7:0] b);
        int unsigned n;
        int unsigned start;
        bit          same;
        n     = used_len();
        start = text_pos;
        // search freezes after the first hit; empty pattern needs no window
        if (hit_seen || n == 0)
            return;
        for (int k = NEEDLE - 1; k > 0; k--)
            win[k] = win[k - 1];
        win[0] = b;
        if (win_fill < NEEDLE)
            win_fill++;
        if (text_pos == IDX_TOP)
            pos_saturated = 1'b1;
        else
            text_pos++;
        if (win_fill < n)
            return;
        same = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            if (upcase(pat_mem[k]) != upcase(win[n - 1 - k]))
                same = 1'b0;
        end
        if (same)
        begin
            hit_seen  = 1'b1;
            first_pos = pos_saturated ? IDX_TOP : start + 1 - n;
        end
    endfunction

    function automatic void clear_search();
        for (int k = 0; k < NEEDLE; k++)
            win[k] = '0;
        win_fill      = 0;
        text_pos      = 0;
        first_pos     = 0;
        pos_saturated = 1'b0;
        hit_seen      = 1'b0;
    endfunction

    function automatic void close_text();
        res_t r;
        r = '0;
        if (used_len() == 0)
        begin
            r.found = 1'b1;
        end
        else
        begin
            r.found       = hit_seen;
            r.match_index = hit_seen ? first_pos[IDX_FIELD_W-1:0] : '0;
            r.overflow    = pos_saturated;
        end
        result_fifo.push_back(r);
        clear_search();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < NEEDLE; k++)
                pat_mem[k] = '0;
            clear_search();
            len_reg  = '0;
            fold_reg = 1'b1;
            result_fifo.delete();
            err_cnt  = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_PATTERN_LENGTH: len_reg = pwdata[LEN_FIELD_W-1:0];
                    ADDR_FOLD_CASE:      fold_reg = pwdata[0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got.found       = m_tuser[0];
                got.match_index = m_tdata;
                got.overflow    = m_tuser[1];
                if (result_fifo.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result word: found=%0d index=%0d overflow=%0d",
                             $time, got.found, got.match_index, got.overflow);
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (got.found !== want.found || got.match_index !== want.match_index
                        || got.overflow !== want.overflow)
                    begin
                        err_cnt++;
                        $display("%0t: result mismatch: expected found=%0d index=%0d ",
                                 $time, want.found, want.match_index,
                                 "overflow=%0d, actual found=%0d index=%0d overflow=%0d",
                                 want.overflow, got.found, got.match_index, got.overflow);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    MODE_PATTERN: pat_mem[s_tdata[3:0]] = s_tdata[11:4];
                    MODE_TEXT:
                    begin
                        shift_in(s_tdata[11:4]);
                        if (s_tlast)
                            close_text();
                    end
                    MODE_END: close_text();
                    default: ;
                endcase
            end
        end
        errors  <= err_cnt;
        waiting <= result_fifo.size();
    end

endmodule

>>> sim/tb_first_substring_match_index.sv
`timescale 1ns / 1ps

module tb_first_substring_match_index;
    import fsmi_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;   // unused code, block drops the word
    localparam logic [2:0] ADDR_PATTERN_LENGTH = {REG_PATTERN_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_FOLD_CASE      = {REG_FOLD_CASE, 2'b00};
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 650;
    localparam int IDX_SPAN      = 1 << INDEX_BITS_DEF;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [3:0] slot, [11:4] byte_value, [15:12] zero
    logic [1:0]  s_tuser;   // [1:0] mode
    logic        s_tlast;   // final_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] match_index
    logic [1:0]  m_tuser;   // [0] found, [1] overflow
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          errors;
    int          waiting;

    bit          src_gaps   = 1'b1;
    bit          sink_gaps  = 1'b1;
    bit          hold_phase = 1'b0;
    bit          hold_done  = 1'b0;
    logic [7:0]  pat_copy [16];
    logic [4:0]  cur_len;
    int          words_sent;

    first_substring_match_index i_dut (.*);

    fsmi_checker i_checker (.*);

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_phase && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                m_tready <= !sink_gaps || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) != 0)
            return 8'h41 + 8'($urandom_range(0, 1)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
        return 8'($urandom);
    endfunction

    task automatic send_word(input logic [1:0] md, input logic [3:0] sl,
                             input logic [7:0] b, input logic lst);
        while (src_gaps && $urandom_range(0, 99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {4'h0, b, sl};
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        if (md == MODE_PATTERN)
            pat_copy[sl] = b;
        if (md != MODE_NONE)
            words_sent++;
    endtask

    task automatic load_slot(input logic [3:0] sl, input logic [7:0] b);
        send_word(MODE_PATTERN, sl, b, 1'($urandom));
    endtask

    // a text closes on its last byte, or on an end word when the text is empty
    // or when close_by_end is set
    task automatic send_text(input logic [7:0] txt [$], input bit close_by_end,
                             input bit noisy);
        for (int j = 0; j < txt.size(); j++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_word(MODE_NONE, 4'($urandom), 8'($urandom), 1'($urandom));
            if (noisy && $urandom_range(0, 29) == 0)
                load_slot(4'($urandom), pick_byte());
            send_word(MODE_TEXT, 4'($urandom), txt[j], !close_by_end && j == txt.size() - 1);
        end
        if (close_by_end || txt.size() == 0)
            send_word(MODE_END, 4'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [4:0] len, input logic fold);
        drain();
        reg_write(ADDR_PATTERN_LENGTH, {27'd0, len});
        reg_write(ADDR_FOLD_CASE, {31'd0, fold});
        cur_len = len;
    endtask

    initial
    begin : stimulus
        logic [7:0] txt [$];
        int         plen;
        int         n;
        int         at;
        int         phase;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cur_len  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern after reset: empty text and a one-byte text both hit at 0
        send_word(MODE_END, 4'h0, 8'h00, 1'b0);
        send_word(MODE_TEXT, 4'h0, 8'h71, 1'b1);
        send_word(MODE_NONE, 4'hF, 8'hFF, 1'b1);

        // fill every slot once so no compare ever sees an unwritten entry
        load_slot(4'd0, 8'h61);
        load_slot(4'd1, 8'h42);
        load_slot(4'd2, 8'h7A);
        load_slot(4'd3, 8'h7B);
        load_slot(4'd4, 8'h00);
        load_slot(4'd5, 8'h60);
        for (int k = 6; k < 15; k++)
            load_slot(4'(k), 8'($urandom));
        load_slot(4'd15, 8'hFF);

        set_config(5'd3, 1'b1);
        send_text('{8'h41, 8'h62, 8'h5A}, 1'b0, 1'b0);
        send_text('{8'h78, 8'h78, 8'h61, 8'h62, 8'h7A}, 1'b0, 1'b0);
        send_text('{8'h61, 8'h62}, 1'b0, 1'b0);
        send_text('{8'h71, 8'h61, 8'h62}, 1'b1, 1'b0);
        send_text('{8'h00, 8'hFF}, 1'b0, 1'b0);

        set_config(5'd3, 1'b0);
        send_text('{8'h61, 8'h42, 8'h7A}, 1'b0, 1'b0);
        send_text('{8'h41, 8'h42, 8'h5A}, 1'b0, 1'b0);

        set_config(5'd16, 1'b0);
        txt.delete();
        for (int k = 0; k < 16; k++)
            txt.push_back(pat_copy[k]);
        send_text(txt, 1'b0, 1'b0);

        // lengths above the store size act as the full store
        set_config(5'd31, 1'b1);
        txt.push_front(8'h41);
        send_text(txt, 1'b0, 1'b0);

        // index saturation: one match completed past the counter range, one miss
        set_config(5'd2, 1'b1);
        load_slot(4'd0, 8'h58);
        load_slot(4'd1, 8'h59);
        src_gaps  = 1'b0;
        sink_gaps <= 1'b0;
        for (int k = 0; k < IDX_SPAN - 1; k++)
            send_word(MODE_TEXT, 4'($urandom), 8'($urandom) & 8'h3F, 1'b0);
        send_word(MODE_TEXT, 4'($urandom), 8'h58, 1'b0);
        send_word(MODE_TEXT, 4'($urandom), 8'h79, 1'b1);
        for (int k = 0; k < IDX_SPAN + 1; k++)
            send_word(MODE_TEXT, 4'($urandom), 8'($urandom) & 8'h3F, k == IDX_SPAN);

        src_gaps   = 1'b1;
        words_sent = 0;
        phase      = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            phase++;
            case ($urandom_range(0, 9))
                0:       set_config(5'd0, 1'($urandom));
                1:       set_config(5'd16, 1'($urandom));
                2:       set_config(5'($urandom_range(17, 31)), 1'($urandom));
                default: set_config(5'($urandom_range(1, 4)), 1'($urandom));
            endcase
            plen = (cur_len > 16) ? 16 : cur_len;
            src_gaps  = ($urandom_range(0, 4) != 0);
            sink_gaps <= ($urandom_range(0, 4) != 0);

            if (phase == 3)
            begin
                // receiver holds off while end words keep coming; input must stall
                hold_phase <= 1'b1;
                for (int k = 0; k < 48; k++)
                    send_word(MODE_END, 4'($urandom), 8'($urandom), 1'($urandom));
                hold_phase <= 1'b0;
            end

            repeat ($urandom_range(0, 4))
            begin
                if (plen > 0 && $urandom_range(0, 1))
                    load_slot(4'($urandom_range(0, plen - 1)), pick_byte());
                else
                    load_slot(4'($urandom), pick_byte());
            end

            repeat ($urandom_range(1, 5))
            begin
                n = $urandom_range(0, 20);
                txt.delete();
                repeat (n) txt.push_back(pick_byte());
                if (plen > 0 && n >= plen && $urandom_range(0, 1))
                begin
                    at = $urandom_range(0, n - plen);
                    for (int j = 0; j < plen; j++)
                        txt[at + j] = pat_copy[j] ^ (($urandom_range(0, 3) == 0) ? 8'h20 : 8'h00);
                end
                send_text(txt, $urandom_range(0, 5) == 0, 1'b1);
            end
        end

        drain();
        if (errors == 0 && waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
src/fsmi_pkg.sv
src/fsmi_cfg.sv
src/fsmi_engine.sv
src/first_substring_match_index.sv
sim/fsmi_checker.sv
sim/tb_first_substring_match_index.sv
